/* rtl/core/mdhl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhl_pkg - shared types and codes of the multiply/divide HI/LO unit
// Operation codes, word width and the record passed down the cell chain.
// ----------------------------------------------------------------------------
package mdhl_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned STEPS  = 32;

   typedef enum logic [1:0] {
      CMD_MULT  = 2'd0,
      CMD_MULTU = 2'd1,
      CMD_DIV   = 2'd2,
      CMD_DIVU  = 2'd3
   } cmd_type;

   // One item in flight: acc/low form the shifting double word
   // (product or remainder/quotient), opd the multiplicand or divisor.
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              neg_hi;
      logic              neg_lo;
      logic              dz;
      logic [WORD_W:0]   acc;
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] opd;
   } stage_type;

endpackage

/* rtl/core/mdhl_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhl_prep - operand conditioning stage
// Takes magnitudes of signed operands and records the result signs.
// ----------------------------------------------------------------------------
module mdhl_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          load,
   input  logic [1:0]                    cmd,
   input  logic [mdhl_pkg::WORD_W-1:0]   operand_a,
   input  logic [mdhl_pkg::WORD_W-1:0]   operand_b,
   output mdhl_pkg::stage_type           stage_out
);

   mdhl_pkg::stage_type stage_ff, stage_in;

   always_comb begin
      logic is_signed;
      logic na;
      logic nb;
      logic zero_b;
      is_signed = (cmd == mdhl_pkg::CMD_MULT) || (cmd == mdhl_pkg::CMD_DIV);
      zero_b    = (operand_b == '0);
      stage_in.is_div = (cmd == mdhl_pkg::CMD_DIV) || (cmd == mdhl_pkg::CMD_DIVU);
      stage_in.dz     = stage_in.is_div && zero_b;
      // a zero divisor keeps the raw dividend so it falls out as the remainder
      na = is_signed && operand_a[mdhl_pkg::WORD_W-1] && !stage_in.dz;
      nb = is_signed && operand_b[mdhl_pkg::WORD_W-1] && !stage_in.dz;
      stage_in.valid  = load;
      stage_in.neg_lo = na ^ nb;
      stage_in.neg_hi = stage_in.is_div ? na : (na ^ nb);
      stage_in.acc    = '0;
      stage_in.low    = na ? (~operand_a + 1'b1) : operand_a;
      stage_in.opd    = nb ? (~operand_b + 1'b1) : operand_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

/* rtl/core/mdhl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhl_cell - one shift-add / shift-subtract step
// Retires one multiplier bit or produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module mdhl_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  mdhl_pkg::stage_type  stage_i,
   output mdhl_pkg::stage_type  stage_o
);

   localparam int unsigned W = mdhl_pkg::WORD_W;

   mdhl_pkg::stage_type stage_ff, stage_in;

   always_comb begin
      logic [W:0]   sum;
      logic [W:0]   sh;
      logic [W+1:0] diff;
      stage_in = stage_i;
      sum  = stage_i.acc + (stage_i.low[0] ? {1'b0, stage_i.opd} : '0);
      sh   = {stage_i.acc[W-1:0], stage_i.low[W-1]};
      diff = {1'b0, sh} - {2'b00, stage_i.opd};
      if (stage_i.is_div) begin
         // restoring step: shift left, keep the trial difference if non-negative
         if (!diff[W+1]) begin
            stage_in.acc = diff[W:0];
            stage_in.low = {stage_i.low[W-2:0], 1'b1};
         end else begin
            stage_in.acc = sh;
            stage_in.low = {stage_i.low[W-2:0], 1'b0};
         end
      end else begin
         // add multiplicand on a set bit, shift the double word right
         stage_in.acc = {1'b0, sum[W:1]};
         stage_in.low = {sum[0], stage_i.low[W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

/* rtl/core/mdhl_post.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhl_post - result sign fixup
// Applies the recorded signs to the product or quotient and remainder.
// ----------------------------------------------------------------------------
module mdhl_post (
   input  mdhl_pkg::stage_type          stage_i,
   output logic [mdhl_pkg::WORD_W-1:0]  hi_value,
   output logic [mdhl_pkg::WORD_W-1:0]  lo_value,
   output logic                         divide_by_zero
);

   localparam int unsigned W = mdhl_pkg::WORD_W;

   always_comb begin
      logic [2*W-1:0] prod;
      prod = {stage_i.acc[W-1:0], stage_i.low};
      if (stage_i.neg_lo) begin
         prod = ~prod + 1'b1;
      end
      if (stage_i.is_div) begin
         hi_value = stage_i.neg_hi ? (~stage_i.acc[W-1:0] + 1'b1) : stage_i.acc[W-1:0];
         lo_value = stage_i.neg_lo ? (~stage_i.low + 1'b1) : stage_i.low;
      end else begin
         hi_value = prod[2*W-1:W];
         lo_value = prod[W-1:0];
      end
      divide_by_zero = stage_i.dz;
   end

endmodule

/* rtl/core/multiply_divide_hi_lo_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiply_divide_hi_lo_unit - pipelined MIPS-style MULT/MULTU/DIV/DIVU
// Returns HI (product upper half or remainder) and LO (product lower half
// or quotient) for each request.
//
// Usage:
//  - req_ channel: cmd, operand_a, operand_b; one transfer per valid/ready.
//  - rsp_ channel: hi_value, lo_value, divide_by_zero; one transfer per
//    request, in request order.
//  - Path: the transfer edge loads the operand conditioning stage, then the
//    32 cells, then one output register, before rsp_valid.
//  - Throughput: one item per cycle while the chain is not stalled. The chain
//    of 32 cells retires one multiplier bit or one quotient bit per cell, each
//    item moving one cell per cycle.
//  - Stall: when the receiver holds rsp_ready low, one more result lands in
//    a spare register; only then does the chain freeze and req_ready drop.
//  - Reset: synchronous, clears all valid flags; nothing else to restore.
//  - Divide by zero: flag set, LO all ones, HI the dividend.
// ----------------------------------------------------------------------------
module multiply_divide_hi_lo_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hi_value,
   output logic [31:0] rsp_lo_value,
   output logic        rsp_divide_by_zero
);

   localparam int unsigned N = mdhl_pkg::STEPS;

   mdhl_pkg::stage_type chain [N+1];

   logic        en;
   logic        out_v_ff,  spare_v_ff;
   logic [31:0] out_hi_ff, out_lo_ff, spare_hi_ff, spare_lo_ff;
   logic        out_dz_ff, spare_dz_ff;
   logic [31:0] fin_hi, fin_lo;
   logic        fin_dz;
   logic        produced;

   // the chain only moves while the spare register is free
   assign en        = !spare_v_ff;
   assign req_ready = en;

   mdhl_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .load      (req_valid && req_ready),
      .cmd       (req_cmd),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      mdhl_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .stage_i (chain[i]),
         .stage_o (chain[i+1])
      );
   end

   mdhl_post u_post (
      .stage_i        (chain[N]),
      .hi_value       (fin_hi),
      .lo_value       (fin_lo),
      .divide_by_zero (fin_dz)
   );

   assign produced = en && chain[N].valid;

   // output register plus spare: drain the spare first, park a result
   // there when the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff   <= 1'b0;
         spare_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ready) begin
         if (spare_v_ff) begin
            out_v_ff   <= 1'b1;
            out_hi_ff  <= spare_hi_ff;
            out_lo_ff  <= spare_lo_ff;
            out_dz_ff  <= spare_dz_ff;
            spare_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= produced;
            out_hi_ff <= fin_hi;
            out_lo_ff <= fin_lo;
            out_dz_ff <= fin_dz;
         end
      end else if (produced) begin
         spare_v_ff  <= 1'b1;
         spare_hi_ff <= fin_hi;
         spare_lo_ff <= fin_lo;
         spare_dz_ff <= fin_dz;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_hi_value       = out_hi_ff;
   assign rsp_lo_value       = out_lo_ff;
   assign rsp_divide_by_zero = out_dz_ff;

endmodule

/* rtl/core/mdhl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdhl_checker - port-level checks of the multiply/divide unit
// Watches the response channel over time.
// ----------------------------------------------------------------------------
module mdhl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hi_value,
   input logic [31:0] rsp_lo_value,
   input logic        rsp_divide_by_zero
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hi_value) && $stable(rsp_lo_value))
      else $error("response payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_dz_quot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_lo_value == 32'hffff_ffff)
      else $error("divide by zero without all-ones quotient");

endmodule

bind multiply_divide_hi_lo_unit mdhl_checker u_mdhl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_hi_value       (rsp_hi_value),
   .rsp_lo_value       (rsp_lo_value),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);
